FILE: src/bkps_pkg.sv
package bkps_pkg;

    localparam int COORD_W = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FORMAT  = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef struct packed {
        logic                              operation;
        logic [3:0]                        key_slot;
        logic signed [COORD_W-1:0]         tick;
        logic signed [COORD_W-1:0]         pos_x;
        logic signed [COORD_W-1:0]         pos_y;
        logic signed [COORD_W-1:0]         pos_z;
        logic signed [COORD_W-1:0]         in_x;
        logic signed [COORD_W-1:0]         in_y;
        logic signed [COORD_W-1:0]         in_z;
        logic signed [COORD_W-1:0]         out_x;
        logic signed [COORD_W-1:0]         out_y;
        logic signed [COORD_W-1:0]         out_z;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] res_x;
        logic signed [COORD_W-1:0] res_y;
        logic signed [COORD_W-1:0] res_z;
        logic [STATUS_W-1:0]       status;
    } result_t;

endpackage

FILE: src/bkps_if.sv
interface bkps_in_if;
    import bkps_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bkps_out_if;
    import bkps_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/bkps_queue.sv
module bkps_queue
    import bkps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t pop_data
);
    item_t      mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            case ({push, pop})
                2'b10: cnt_reg <= cnt_reg + 2'd1;
                2'b01: cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end
endmodule

FILE: src/bkps_engine.sv
module bkps_engine
    import bkps_pkg::*;
#(
    parameter int MAX_KEYS = 16,
    parameter int FRAC_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic [4:0] key_count,
    input  logic    in_valid,
    input  item_t   in_data,
    output logic    in_pop,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res_data
);
    localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int TW = FRAC_BITS + 1;
    localparam int DW = 33 + FRAC_BITS;
    localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;
    localparam int PW = 2 * TW + 2;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_CHK   = 12'b000000000010,
        S_CHKW  = 12'b000000000100,
        S_SRCH  = 12'b000000001000,
        S_SRCHW = 12'b000000010000,
        S_LOAD  = 12'b000000100000,
        S_DIV   = 12'b000001000000,
        S_WGT   = 12'b000010000000,
        S_FETCH = 12'b000100000000,
        S_MAC   = 12'b001000000000,
        S_RND   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    // one entry per key, coordinates packed as {z, y, x}
    logic signed [31:0] tick_mem [MAX_KEYS];
    logic [95:0]        pos_mem  [MAX_KEYS];
    logic [95:0]        inc_mem  [MAX_KEYS];
    logic [95:0]        outg_mem [MAX_KEYS];

    state_t state_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] idx_reg;
    logic signed [31:0] tk_reg;
    logic signed [31:0] trd_reg;
    logic signed [31:0] tprev_reg;
    logic [KW-1:0] up_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] num_reg;
    logic [32:0] len_reg;
    logic [TW-1:0] t_reg;
    logic [6:0] dcnt_reg;
    logic [2:0] wstep_reg;
    logic [TW-1:0] ss_reg, tt_reg;
    logic [TW+1:0] w_reg [4];
    logic [1:0] comp_reg;
    logic [2:0] term_reg;
    logic signed [31:0] pt_reg;
    logic signed [71:0] acc_reg;
    logic [1:0] st_reg;
    logic signed [31:0] rx_reg, ry_reg;
    result_t res_reg;
    logic res_valid_reg;

    logic [CW-1:0] n_eff;
    assign n_eff = ({27'd0, key_count} > 32'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(key_count);

    logic start;
    assign start = (state_reg == S_IDLE) && in_valid && !res_valid_reg;
    assign in_pop = start;
    assign res_valid = res_valid_reg;
    assign res_data = res_reg;

    // key writes
    always_ff @(posedge clk)
    begin
        if (start && in_data.operation == OP_WRITE &&
            {28'd0, in_data.key_slot} < 32'(MAX_KEYS))
        begin
            tick_mem[KW'(in_data.key_slot)] <= in_data.tick;
            pos_mem[KW'(in_data.key_slot)]  <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
            inc_mem[KW'(in_data.key_slot)]  <= {in_data.in_z, in_data.in_y, in_data.in_x};
            outg_mem[KW'(in_data.key_slot)] <= {in_data.out_z, in_data.out_y, in_data.out_x};
        end
    end

    // registered single-port style reads
    logic [KW-1:0] rd_key;
    logic [KW-1:0] rd_pk;
    logic [95:0] pt_word;
    logic signed [31:0] pt_rd;
    always_comb
    begin
        rd_key = idx_reg[KW-1:0];
        rd_pk = (term_reg == 3'd0 || term_reg == 3'd1) ? up_reg - KW'(1) : up_reg;
        case (term_reg)
            3'd0: pt_word = pos_mem[rd_pk];
            3'd1: pt_word = outg_mem[rd_pk];
            3'd2: pt_word = inc_mem[rd_pk];
            default: pt_word = pos_mem[rd_pk];
        endcase
        case (comp_reg)
            2'd0: pt_rd = pt_word[31:0];
            2'd1: pt_rd = pt_word[63:32];
            default: pt_rd = pt_word[95:64];
        endcase
    end

    always_ff @(posedge clk)
    begin
        trd_reg <= tick_mem[rd_key];
        pt_reg <= pt_rd;
    end

    logic [TW-1:0] s_val;
    assign s_val = ONE - t_reg;

    function automatic logic [PW-1:0] rnd(input logic [2*PW-1:0] x);
        logic [2*PW-1:0] y;
        y = (x + ((2*PW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return y[PW-1:0];
    endfunction

    // one narrow multiplier shared by the weight steps
    logic [TW-1:0] wm_a, wm_b;
    logic [2*TW-1:0] wm_p;
    logic [2*TW+1:0] wm_p3;
    always_comb
    begin
        case (wstep_reg)
            3'd0:
            begin
                wm_a = s_val;
                wm_b = s_val;
            end
            3'd1:
            begin
                wm_a = t_reg;
                wm_b = t_reg;
            end
            3'd2:
            begin
                wm_a = ss_reg;
                wm_b = s_val;
            end
            3'd3:
            begin
                wm_a = ss_reg;
                wm_b = t_reg;
            end
            3'd4:
            begin
                wm_a = tt_reg;
                wm_b = s_val;
            end
            default:
            begin
                wm_a = tt_reg;
                wm_b = t_reg;
            end
        endcase
        wm_p = wm_a * wm_b;
        wm_p3 = {1'b0, wm_p, 1'b0} + {2'b00, wm_p};
    end

    logic signed [TW+2:0] mac_w;
    logic signed [TW+34:0] mac_p;
    assign mac_w = signed'({1'b0, w_reg[term_reg[1:0]]});
    assign mac_p = mac_w * pt_reg;

    logic [DW-1:0] rem_sh;
    assign rem_sh = {rem_reg[DW-2:0], num_reg[DW-1]};

    logic signed [71:0] acc_b;
    logic signed [31:0] sat_v;
    logic sat_f;
    always_comb
    begin
        acc_b = acc_reg + (72'sd1 <<< (FRAC_BITS - 1));
        acc_b = acc_b >>> FRAC_BITS;
        sat_f = 1'b0;
        sat_v = acc_b[31:0];
        if (acc_b > 72'sd2147483647)
        begin
            sat_v = 32'h7fffffff;
            sat_f = 1'b1;
        end
        else if (acc_b < -72'sd2147483648)
        begin
            sat_v = 32'h80000000;
            sat_f = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        tk_reg <= in_data.tick;
                        n_reg <= n_eff;
                        st_reg <= ST_OK;
                        idx_reg <= '0;
                        if (in_data.operation == OP_WRITE || n_eff == '0)
                        begin
                            res_reg <= '0;
                            res_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_CHK;
                        end
                    end
                end
                S_CHK: state_reg <= S_CHKW;
                S_CHKW:
                begin
                    // ordering check across keys in use
                    if (idx_reg != '0 && trd_reg <= tprev_reg)
                    begin
                        res_reg <= '{0, 0, 0, ST_FORMAT};
                        res_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (idx_reg + CW'(1) == n_reg)
                    begin
                        idx_reg <= '0;
                        state_reg <= S_SRCH;
                    end
                    else
                    begin
                        tprev_reg <= trd_reg;
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_CHK;
                    end
                end
                S_SRCH: state_reg <= S_SRCHW;
                S_SRCHW:
                begin
                    if (idx_reg == '0 && tk_reg <= trd_reg)
                    begin
                        up_reg <= '0;
                        term_reg <= 3'd3;
                        comp_reg <= 2'd0;
                        wstep_reg <= 3'd7;
                        state_reg <= S_LOAD;
                    end
                    else if (idx_reg + CW'(1) == n_reg && tk_reg >= trd_reg)
                    begin
                        up_reg <= idx_reg[KW-1:0];
                        term_reg <= 3'd3;
                        comp_reg <= 2'd0;
                        wstep_reg <= 3'd7;
                        state_reg <= S_LOAD;
                    end
                    else if (idx_reg != '0 && tk_reg < trd_reg)
                    begin
                        up_reg <= idx_reg[KW-1:0];
                        len_reg <= 33'({trd_reg[31], trd_reg} - {tprev_reg[31], tprev_reg});
                        num_reg <= DW'(33'({tk_reg[31], tk_reg} - {tprev_reg[31], tprev_reg}))
                                   << FRAC_BITS;
                        rem_reg <= '0;
                        dcnt_reg <= 7'(DW);
                        wstep_reg <= 3'd0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        tprev_reg <= trd_reg;
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_SRCH;
                    end
                end
                S_LOAD:
                begin
                    // clamp: emit a key position directly
                    comp_reg <= comp_reg + 2'd1;
                    if (comp_reg == 2'd1) rx_reg <= pt_reg;
                    if (comp_reg == 2'd2) ry_reg <= pt_reg;
                    if (comp_reg == 2'd3)
                    begin
                        res_reg <= '{rx_reg, ry_reg, pt_reg, ST_OK};
                        res_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    // restoring divide, one quotient bit per cycle
                    num_reg <= {num_reg[DW-2:0], 1'b0};
                    if (rem_sh >= DW'(len_reg))
                    begin
                        rem_reg <= rem_sh - DW'(len_reg);
                        t_reg <= {t_reg[TW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        t_reg <= {t_reg[TW-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 7'd1;
                    if (dcnt_reg == 7'd1) state_reg <= S_WGT;
                end
                S_WGT:
                begin
                    wstep_reg <= wstep_reg + 3'd1;
                    case (wstep_reg)
                        3'd0: ss_reg <= TW'(rnd((2*PW)'(wm_p)));
                        3'd1: tt_reg <= TW'(rnd((2*PW)'(wm_p)));
                        3'd2: w_reg[0] <= (TW+2)'(rnd((2*PW)'(wm_p)));
                        3'd3: w_reg[1] <= (TW+2)'(rnd((2*PW)'(wm_p3)));
                        3'd4: w_reg[2] <= (TW+2)'(rnd((2*PW)'(wm_p3)));
                        default:
                        begin
                            w_reg[3] <= (TW+2)'(rnd((2*PW)'(wm_p)));
                            term_reg <= 3'd0;
                            comp_reg <= 2'd0;
                            acc_reg <= '0;
                            state_reg <= S_FETCH;
                        end
                    endcase
                end
                S_FETCH: state_reg <= S_MAC;
                S_MAC:
                begin
                    acc_reg <= acc_reg + 72'(mac_p);
                    if (term_reg == 3'd3)
                    begin
                        term_reg <= 3'd0;
                        state_reg <= S_RND;
                    end
                    else
                    begin
                        term_reg <= term_reg + 3'd1;
                        state_reg <= S_FETCH;
                    end
                end
                S_RND:
                begin
                    if (sat_f) st_reg <= ST_RANGE;
                    acc_reg <= '0;
                    comp_reg <= comp_reg + 2'd1;
                    if (comp_reg == 2'd0) rx_reg <= sat_v;
                    if (comp_reg == 2'd1) ry_reg <= sat_v;
                    state_reg <= (comp_reg == 2'd2) ? S_OUT : S_FETCH;
                    if (comp_reg == 2'd2) res_reg.res_z <= sat_v;
                end
                S_OUT:
                begin
                    res_reg.res_x <= rx_reg;
                    res_reg.res_y <= ry_reg;
                    res_reg.status <= st_reg;
                    res_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: src/bezier_keyframe_position_sampler_unit.sv
// Cubic Bezier keyframe sampler. A front queue of two words takes items while
// the engine works; every item gives exactly one result word. A sample first
// checks the key ticks of the keys in use, then searches the segment, then runs a
// restoring divider one quotient bit per cycle, six weight steps and a shared
// multiply-accumulate over 12 terms.
// Samples that clamp to the first or last key skip the divide and the MAC.
module bezier_keyframe_position_sampler_unit
    import bkps_pkg::*;
#(
    parameter int MAX_KEYS = 16,
    parameter int FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    bkps_in_if.sink    in_ch,
    bkps_out_if.source out_ch
);
    logic [4:0] key_count_reg;
    logic       q_full, q_empty, q_pop;
    item_t      q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= 5'd0;
        end
        else if (cfg_we)
        begin
            key_count_reg <= cfg_wdata;
        end
    end

    assign in_ch.ready = !q_full;

    bkps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_ch.valid && !q_full),
        .push_data (in_ch.data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_data)
    );

    bkps_engine #(
        .MAX_KEYS  (MAX_KEYS),
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_count (key_count_reg),
        .in_valid  (!q_empty),
        .in_data   (q_data),
        .in_pop    (q_pop),
        .res_valid (out_ch.valid),
        .res_ready (out_ch.ready),
        .res_data  (out_ch.data)
    );
endmodule

FILE: src/bkps_checker.sv
module bkps_checker
    import bkps_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("bad status code");
    a_format_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_FORMAT |->
        out_data.res_x == 0 && out_data.res_y == 0 && out_data.res_z == 0)
        else $error("format error with nonzero position");
    a_no_out_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result after reset");
    a_ready_reset: assert property (@(posedge clk)
        !rst_n |=> in_ready)
        else $error("input not ready after reset");
endmodule

bind bezier_keyframe_position_sampler_unit bkps_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

FILE: tb/tb_bezier_keyframe_position_sampler_unit.sv
module tb_bezier_keyframe_position_sampler_unit;
    import bkps_pkg::*;

    localparam int NUM_KEYS = 16;
    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [4:0] cfg_wdata = '0;

    bkps_in_if in_ch ();
    bkps_out_if out_ch ();

    bezier_keyframe_position_sampler_unit #(.MAX_KEYS(NUM_KEYS), .FRAC_BITS(FRAC)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always #2 clk = ~clk;

    // predictor state
    logic signed [31:0] mdl_tick [NUM_KEYS];
    logic signed [31:0] mdl_pos [NUM_KEYS][3];
    logic signed [31:0] mdl_in [NUM_KEYS][3];
    logic signed [31:0] mdl_out [NUM_KEYS][3];
    logic [4:0] mdl_count = '0;
    bit written [NUM_KEYS];

    item_t pending_items[$];
    result_t expected_positions[$];
    int errors = 0;
    int n_samples = 0;
    int n_writes = 0;
    int n_clamped = 0;
    int n_format = 0;
    int n_range = 0;
    int n_results = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit timed_out = 1'b0;
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
        errors++;
    endtask

    function automatic logic [63:0] rnd_u(input logic [63:0] x);
        return (x + 64'd32768) >> FRAC;
    endfunction

    function automatic result_t sample_position(input logic signed [31:0] tk);
        result_t r;
        int n;
        int up;
        logic signed [63:0] elapsed;
        logic signed [63:0] len;
        logic [63:0] t, s, ss, tt;
        logic [63:0] w [4];
        logic signed [127:0] acc;
        logic signed [127:0] rr;
        r = '0;
        n = (mdl_count > NUM_KEYS) ? NUM_KEYS : mdl_count;
        for (int i = 1; i < n; i++)
            if (mdl_tick[i] <= mdl_tick[i-1])
            begin
                r.status = ST_FORMAT;
                n_format++;
                return r;
            end
        if (n == 0)
            return r;
        if (tk <= mdl_tick[0] || tk >= mdl_tick[n-1])
        begin
            up = (tk <= mdl_tick[0]) ? 0 : n - 1;
            r.res_x = mdl_pos[up][0];
            r.res_y = mdl_pos[up][1];
            r.res_z = mdl_pos[up][2];
            n_clamped++;
            return r;
        end
        up = 1;
        while (up < n - 1 && tk >= mdl_tick[up])
            up++;
        elapsed = 64'(tk) - 64'(mdl_tick[up-1]);
        len = 64'(mdl_tick[up]) - 64'(mdl_tick[up-1]);
        t = (64'(elapsed) << FRAC) / 64'(len);
        s = 64'd65536 - t;
        ss = rnd_u(s * s);
        tt = rnd_u(t * t);
        w[0] = rnd_u(ss * s);
        w[1] = rnd_u(3 * ss * t);
        w[2] = rnd_u(3 * tt * s);
        w[3] = rnd_u(tt * t);
        r.status = ST_OK;
        for (int c = 0; c < 3; c++)
        begin
            acc = $signed({64'd0, w[0]}) * 128'(mdl_pos[up-1][c])
                + $signed({64'd0, w[1]}) * 128'(mdl_out[up-1][c])
                + $signed({64'd0, w[2]}) * 128'(mdl_in[up][c])
                + $signed({64'd0, w[3]}) * 128'(mdl_pos[up][c]);
            rr = (acc + 128'sd32768) >>> FRAC;
            if (rr > 128'sd2147483647)
            begin
                rr = 128'sd2147483647;
                r.status = ST_RANGE;
            end
            if (rr < -128'sd2147483648)
            begin
                rr = -128'sd2147483648;
                r.status = ST_RANGE;
            end
            if (c == 0) r.res_x = rr[31:0];
            else if (c == 1) r.res_y = rr[31:0];
            else r.res_z = rr[31:0];
        end
        if (r.status == ST_RANGE) n_range++;
        return r;
    endfunction

    function automatic result_t predict(input item_t it);
        if (it.operation == OP_WRITE)
        begin
            mdl_tick[it.key_slot] = it.tick;
            mdl_pos[it.key_slot] = '{it.pos_x, it.pos_y, it.pos_z};
            mdl_in[it.key_slot] = '{it.in_x, it.in_y, it.in_z};
            mdl_out[it.key_slot] = '{it.out_x, it.out_y, it.out_z};
            written[it.key_slot] = 1'b1;
            n_writes++;
            return '0;
        end
        n_samples++;
        return sample_position(it.tick);
    endfunction

    // driver
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end
        else if (in_ch.valid && !in_taken)
        begin
        end
        else if (send_gap > 0)
        begin
            in_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_items.size() > 0)
        begin
            in_ch.data <= pending_items.pop_front();
            in_ch.valid <= 1'b1;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        end
        else
            in_ch.valid <= 1'b0;
    end

    // a word is accepted this cycle if valid was high while ready sampled high
    initial in_ch.valid = 1'b0;
    initial in_ch.data = '0;
    initial out_ch.ready = 1'b0;

    always @(posedge clk)
    begin
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_positions.push_back(predict(in_ch.data));
    end

    // monitor
    int recv_gap = 0;
    always @(posedge clk)
    begin
        out_taken <= rst_n && out_ch.valid && out_ch.ready;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_results++;
            if (expected_positions.size() == 0)
            begin
                report_mismatch("unexpected word", out_ch.data.res_x, 32'd0);
            end
            else
            begin
                result_t e;
                e = expected_positions.pop_front();
                if (out_ch.data.res_x !== e.res_x) report_mismatch("res_x", out_ch.data.res_x, e.res_x);
                if (out_ch.data.res_y !== e.res_y) report_mismatch("res_y", out_ch.data.res_y, e.res_y);
                if (out_ch.data.res_z !== e.res_z) report_mismatch("res_z", out_ch.data.res_z, e.res_z);
                if (out_ch.data.status !== e.status)
                    report_mismatch("status", 32'(out_ch.data.status), 32'(e.status));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            out_ch.ready <= 1'b0;
        else if (out_taken)
        begin
            if ($urandom_range(0, 3) == 0)
                recv_gap <= 0;
            else
            begin
                recv_gap <= $urandom_range(0, 14);
                out_ch.ready <= 1'b0;
            end
        end
        else if (recv_gap > 0)
        begin
            out_ch.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t key_item(input int slot, input logic [31:0] tk, input int mode);
        item_t it;
        it.operation = OP_WRITE;
        it.key_slot = 4'(slot);
        it.tick = tk;
        // mode 0 modest coords, 1 full-range coords
        it.pos_x = (mode == 1) ? edge_word() : $signed($urandom) >>> $urandom_range(4, 20);
        it.pos_y = (mode == 1) ? edge_word() : $signed($urandom) >>> $urandom_range(4, 20);
        it.pos_z = (mode == 1) ? edge_word() : $signed($urandom) >>> $urandom_range(4, 20);
        it.in_x = (mode == 1) ? edge_word() : $signed($urandom) >>> $urandom_range(4, 20);
        it.in_y = (mode == 1) ? edge_word() : $signed($urandom) >>> $urandom_range(4, 20);
        it.in_z = (mode == 1) ? edge_word() : $signed($urandom) >>> $urandom_range(4, 20);
        it.out_x = (mode == 1) ? edge_word() : $signed($urandom) >>> $urandom_range(4, 20);
        it.out_y = (mode == 1) ? edge_word() : $signed($urandom) >>> $urandom_range(4, 20);
        it.out_z = (mode == 1) ? edge_word() : $signed($urandom) >>> $urandom_range(4, 20);
        return it;
    endfunction

    function automatic item_t sample_item(input logic [31:0] tk);
        item_t it;
        it = key_item($urandom_range(0, 15), $urandom, 1);
        it.operation = OP_SAMPLE;
        it.tick = tk;
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_ch.valid || expected_positions.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_key_count(input int cnt);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 5'(cnt);
        @(negedge clk);
        cfg_we <= 1'b0;
        mdl_count = 5'(cnt);
    endtask

    // fill slots 0..cnt-1 with increasing ticks from base with random spacing
    task automatic load_keys(input int cnt, input logic [31:0] base, input int spread,
                             input int mode, output logic [31:0] last_tick);
        logic [31:0] tk;
        tk = base;
        last_tick = base;
        for (int i = 0; i < cnt; i++)
        begin
            pending_items.push_back(key_item(i, tk, mode));
            last_tick = tk;
            tk = tk + 1 + $urandom_range(0, spread);
        end
    endtask

    initial
    begin
        logic [31:0] first_tk, last_tk;
        int cnt;
        int total;
        for (int i = 0; i < NUM_KEYS; i++) written[i] = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no keys in use
        pending_items.push_back(sample_item(32'h80000000));
        pending_items.push_back(sample_item(32'h7fffffff));
        wait_idle();

        // directed: full table, extreme ticks at both ends
        pending_items.push_back(key_item(0, 32'h80000000, 1));
        for (int i = 1; i < 15; i++)
            pending_items.push_back(key_item(i, 32'(i * 1000), 0));
        pending_items.push_back(key_item(15, 32'h7fffffff, 1));
        wait_idle();
        set_key_count(16);
        pending_items.push_back(sample_item(32'h80000000));
        pending_items.push_back(sample_item(32'h7fffffff));
        pending_items.push_back(sample_item(32'h80000001));
        pending_items.push_back(sample_item(32'd500));
        pending_items.push_back(sample_item(32'd1000));
        pending_items.push_back(sample_item(32'd14500));
        pending_items.push_back(sample_item(32'h7ffffffe));
        wait_idle();
        // count beyond table
        set_key_count(31);
        pending_items.push_back(sample_item(32'd7321));
        // ticks not increasing
        pending_items.push_back(key_item(5, 32'd4000, 0));
        pending_items.push_back(sample_item(32'd7321));
        wait_idle();
        set_key_count(1);
        pending_items.push_back(sample_item(32'd0));
        wait_idle();

        // long receiver hold-off while the sender keeps offering
        set_key_count(16);
        pending_items.push_back(key_item(5, 32'd5000, 0));
        for (int i = 0; i < 8; i++)
            pending_items.push_back(sample_item($urandom_range(0, 16000)));
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
        wait_idle();

        total = 0;
        while (total < 900)
        begin
            cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 6);
            if (cnt > 16 && $urandom_range(0, 1)) cnt = 16;
            case ($urandom_range(0, 3))
                0: first_tk = 32'h80000000 + $urandom_range(0, 100);
                1: first_tk = $urandom_range(0, 1000) - 500;
                default: first_tk = $urandom;
            endcase
            if (first_tk[31] == 1'b0 && first_tk > 32'h70000000) first_tk = 32'h10000000;
            load_keys((cnt > 16) ? 16 : cnt, first_tk,
                      ($urandom_range(0, 3) == 0) ? 32'h07ffffff : $urandom_range(1, 3000),
                      ($urandom_range(0, 4) == 0) ? 1 : 0, last_tk);
            if ($urandom_range(0, 9) == 0 && cnt > 2)
                pending_items.push_back(key_item($urandom_range(1, cnt - 1), first_tk, 0));
            total += (cnt > 16) ? 16 : cnt;
            wait_idle();
            set_key_count(cnt);
            for (int j = 0; j < 12; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                    pending_items.push_back(sample_item($urandom));
                else
                    pending_items.push_back(sample_item(first_tk +
                        $urandom_range(0, 32'(last_tk - first_tk) + 2) - 1));
                total++;
            end
            wait_idle();
        end
        set_key_count(0);
        pending_items.push_back(sample_item($urandom));
        wait_idle();

        $display("covered %0d key writes and %0d samples: %0d clamped, %0d format errors",
                 n_writes, n_samples, n_clamped, n_format);
        $display("%0d saturated samples, %0d result words checked", n_range, n_results);
        if (errors == 0 && expected_positions.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
